// ----- hw/rtl/f2i16_pkg.sv -----
// Shared types and constants for the float32 scale-and-convert pipeline.
// No dependencies.
package f2i16_pkg;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam int unsigned EXP_OFFSET  = 253;
  localparam logic [7:0]  EXP_SPECIAL = 8'hFF;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
  } flags_t;

  // leading zero count of a 48-bit product, 48 when the word is zero
  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && m[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/float_to_int16_scaler.sv -----
// Top level: float32 sample times float32 scale, RNE to float32, then clamp and
// half-up round to signed 16 bits. Depends on f2i16_pkg.
//
// Usage: one beat enters per cycle while s_tready is high, and each result passes
// through five register stages (unpack and 24x24 multiply, leading-zero count,
// normalize and round, align shift, clamp and output) before it leaves. Each stage
// holds while the one after it is full and stalled, so a finished result may wait
// on m_tready while new beats keep entering.
// The scale factor resets to 1.0 and is written through cfg_valid/cfg_data;
// write it only while the pipeline is empty.
module float_to_int16_scaler
  import f2i16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [15:0] word_value, [16] was_saturated, [17] was_nan
);

  logic [31:0] scale;

  logic        va, vb, vc, vd, ve;
  logic        ready_a, ready_b, ready_c, ready_d, ready_e;

  logic [47:0] a_prod;
  logic [8:0]  a_esum;
  flags_t      a_fl;

  logic [47:0] b_prod;
  logic [8:0]  b_esum;
  logic [5:0]  b_lz;
  flags_t      b_fl;

  logic [24:0] c_sig;
  logic signed [10:0] c_exp;
  flags_t      c_fl;

  logic [16:0] d_int;
  logic        d_half;
  logic        d_rest;
  logic        d_big;
  flags_t      d_fl;

  logic [15:0] e_word;
  logic        e_sat;
  logic        e_nan;

  assign ready_e  = !ve || m_tready;
  assign ready_d  = !vd || ready_e;
  assign ready_c  = !vc || ready_d;
  assign ready_b  = !vb || ready_c;
  assign ready_a  = !va || ready_b;
  assign s_tready = ready_a;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_valid) begin
      scale <= cfg_data;
    end
  end

  // stage A: unpack and multiply significands
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic        a_nan_in, s_nan_in, a_inf_in, s_inf_in, a_zero_in, s_zero_in;
  flags_t      fl_in;

  always_comb begin
    ea = s_tdata[30:23];
    fa = s_tdata[22:0];
    eb = scale[30:23];
    fb = scale[22:0];
    ma = {ea != 8'd0, fa};
    mb = {eb != 8'd0, fb};
    a_nan_in  = (ea == EXP_SPECIAL) && (fa != 23'd0);
    s_nan_in  = (eb == EXP_SPECIAL) && (fb != 23'd0);
    a_inf_in  = (ea == EXP_SPECIAL) && (fa == 23'd0);
    s_inf_in  = (eb == EXP_SPECIAL) && (fb == 23'd0);
    a_zero_in = (ea == 8'd0) && (fa == 23'd0);
    s_zero_in = (eb == 8'd0) && (fb == 23'd0);
    fl_in.sign = s_tdata[31] ^ scale[31];
    fl_in.nan  = a_nan_in || s_nan_in || (a_inf_in && s_zero_in) || (s_inf_in && a_zero_in);
    fl_in.inf  = (a_inf_in || s_inf_in) && !fl_in.nan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      a_prod <= {24'd0, ma} * {24'd0, mb};
      a_esum <= 9'((ea == 8'd0) ? 8'd1 : ea) + 9'((eb == 8'd0) ? 8'd1 : eb);
      a_fl   <= fl_in;
    end
  end

  // stage B: leading zero count
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      b_prod <= a_prod;
      b_esum <= a_esum;
      b_lz   <= lzc48(a_prod);
      b_fl   <= a_fl;
    end
  end

  // stage C: normalize and round to 24 significant bits, nearest even
  logic [47:0] mn;
  logic        rnd;
  logic signed [10:0] exp_next;

  always_comb begin
    mn  = b_prod << b_lz;
    rnd = mn[23] && (mn[24] || (mn[22:0] != 23'd0));
    exp_next = $signed({2'b00, b_esum}) - $signed(11'(EXP_OFFSET))
               - $signed({5'd0, b_lz});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (ready_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c) begin
      c_sig <= {1'b0, mn[47:24]} + 25'(rnd);
      c_exp <= (b_prod == 48'd0) ? -11'sd300 : exp_next;
      c_fl  <= b_fl;
    end
  end

  // stage D: align to fixed point, value = sig * 2^(exp-23)
  logic [41:0] aligned;
  logic [4:0]  shamt;
  logic        tiny;

  always_comb begin
    tiny    = c_exp < -11'sd2;
    shamt   = tiny ? 5'd0 : 5'(c_exp + 11'sd2);
    aligned = tiny ? 42'd0 : ({17'd0, c_sig} << shamt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (ready_d) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d) begin
      d_big  <= c_exp > 11'sd15;
      d_int  <= aligned[41:25];
      d_half <= aligned[24];
      d_rest <= aligned[23:0] != 24'd0;
      d_fl   <= c_fl;
    end
  end

  // stage E: clamp and half-up round
  logic        sat_next;
  logic [16:0] mag;
  logic [15:0] word_next;

  always_comb begin
    if (!d_fl.sign) begin
      sat_next = d_fl.inf || d_big || (d_int > 17'd32767)
                 || ((d_int == 17'd32767) && (d_half || d_rest));
      mag = d_int + 17'(d_half);
    end else begin
      sat_next = d_fl.inf || d_big || (d_int > 17'd32768)
                 || ((d_int == 17'd32768) && (d_half || d_rest));
      mag = d_int + 17'(d_half && d_rest);
    end
    if (d_fl.nan) begin
      word_next = 16'd0;
    end else if (sat_next) begin
      word_next = d_fl.sign ? 16'h8000 : 16'h7FFF;
    end else begin
      word_next = d_fl.sign ? 16'(17'd0 - mag) : mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (ready_e) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_e) begin
      e_word <= word_next;
      e_sat  <= sat_next && !d_fl.nan;
      e_nan  <= d_fl.nan;
    end
  end

  assign m_tvalid = ve;
  assign m_tdata  = {6'd0, e_nan, e_sat, e_word};

endmodule

// ----- tb/float_to_int16_scaler_tb.sv -----
// Self-checking bench for float_to_int16_scaler: drives float32 sample beats and
// scale writes, predicts each int16 word in bit-exact integer arithmetic.
// Depends on the RTL top level and f2i16_pkg.
module float_to_int16_scaler_tb;
  import f2i16_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [15:0] word;
    logic        sat;
    logic        nan;
  } word_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  logic [31:0] scale_now;
  word_t       pending_words[$];
  int          mismatches;
  int          cycle_count;
  int          hold_cycles;
  bit          tx_idle_on;
  bit          rx_idle_on;

  float_to_int16_scaler dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // float32 product rounded to nearest even, then clamp and floor(x + 0.5)
  function automatic word_t scale_to_word(input logic [31:0] smp, input logic [31:0] scl);
    word_t       res;
    logic        sgn, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, fh, fr;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    logic [63:0] r, ipart;
    int          ex, k, q, sh;
    res = '0;
    sgn = smp[31] ^ scl[31];
    nan_a = (smp[30:23] == 8'hFF) && (smp[22:0] != 0);
    nan_b = (scl[30:23] == 8'hFF) && (scl[22:0] != 0);
    inf_a = (smp[30:23] == 8'hFF) && (smp[22:0] == 0);
    inf_b = (scl[30:23] == 8'hFF) && (scl[22:0] == 0);
    zero_a = smp[30:0] == 0;
    zero_b = scl[30:0] == 0;
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
      res.nan = 1'b1;
      return res;
    end
    if (inf_a || inf_b) begin
      res.sat = 1'b1;
      res.word = sgn ? 16'h8000 : 16'h7FFF;
      return res;
    end
    if (zero_a || zero_b) return res;
    ma = {smp[30:23] != 0, smp[22:0]};
    mb = {scl[30:23] != 0, scl[22:0]};
    ex = (smp[30:23] == 0 ? 1 : int'(smp[30:23])) + (scl[30:23] == 0 ? 1 : int'(scl[30:23])) - 300;
    prod = {24'd0, ma} * {24'd0, mb};
    k = 47;
    while (!prod[k]) k--;
    if (k + ex >= 16) begin
      res.sat = 1'b1;
      res.word = sgn ? 16'h8000 : 16'h7FFF;
      return res;
    end
    // quantum of the float32 result, subnormal floor at 2^-149
    q = k + ex - 23;
    if (q < -149) q = -149;
    sh = q - ex;
    if (sh <= 0) r = 64'(prod) << (-sh);
    else if (sh > 48) r = 0;
    else begin
      r = 64'(prod >> sh);
      fh = prod[sh-1];
      fr = (prod & ((48'd1 << (sh - 1)) - 48'd1)) != 0;
      if (fh && (fr || r[0])) r = r + 1;
    end
    if (q >= 0) begin
      ipart = r << q;
      fh = 1'b0;
      fr = 1'b0;
    end else if (-q > 25) begin
      ipart = 0;
      fh = 1'b0;
      fr = r != 0;
    end else begin
      ipart = r >> (-q);
      fh = r[-q-1];
      fr = (r & ((64'd1 << (-q - 1)) - 64'd1)) != 0;
    end
    if (!sgn) begin
      if (ipart > 32767 || (ipart == 32767 && (fh || fr))) begin
        res.sat = 1'b1;
        res.word = 16'h7FFF;
      end else res.word = 16'(ipart + 64'(fh));
    end else begin
      if (ipart > 32768 || (ipart == 32768 && (fh || fr))) begin
        res.sat = 1'b1;
        res.word = 16'h8000;
      end else res.word = 16'(64'd0 - (ipart + 64'(fh && fr)));
    end
    return res;
  endfunction

  function automatic int draw_gap(input bit on);
    if (!on) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // receiver: random stalls per beat, plus a long hold-off on request
  int rx_gap;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_tvalid && m_tready) rx_gap = draw_gap(rx_idle_on);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (rx_gap > 0) begin
        m_tready <= 1'b0;
        rx_gap--;
      end else m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected beat", int'(m_tdata), 0);
      end else begin
        want = pending_words.pop_front();
        if (m_tdata[15:0] !== want.word)
          report_mismatch("word_value", $signed(m_tdata[15:0]), $signed(want.word));
        if (m_tdata[16] !== want.sat) report_mismatch("was_saturated", m_tdata[16], want.sat);
        if (m_tdata[17] !== want.nan) report_mismatch("was_nan", m_tdata[17], want.nan);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout, %0d results outstanding", pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_sample(input logic [31:0] bits);
    int gap;
    gap = draw_gap(tx_idle_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= bits;
    do @(posedge clk); while (!s_tready);
    pending_words.push_back(scale_to_word(bits, scale_now));
  endtask

  // drop valid right after the last accepted beat, then wait for every result
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [31:0] v);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_now = v;
  endtask

  // sample whose product with the current scale lands near the 16-bit range
  function automatic logic [31:0] near_range_sample();
    int e;
    e = 141 - (int'(scale_now[30:23]) - 127) + $urandom_range(0, 26) - 22;
    if (e < 0) e = 0;
    if (e > 254) e = 254;
    return {1'($urandom), 8'(e), 23'($urandom)};
  endfunction

  task automatic test_directed_unity();
    logic [31:0] vec[$];
    vec = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000,
            32'hBF00_0000, 32'h3FC0_0000, 32'hBFC0_0000, 32'h4020_0000, 32'h46FF_FE00,
            32'h46FF_FE80, 32'h46FF_FF00, 32'h4700_0000, 32'hC700_0000, 32'hC700_0080,
            32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF};
    foreach (vec[i]) send_sample(vec[i]);
  endtask

  task automatic test_special_scales();
    write_scale(32'h0000_0000);
    send_sample(32'h7F80_0000);
    send_sample(32'h3F80_0000);
    write_scale(32'h7F80_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hBF80_0000);
    write_scale(32'hFFFF_FFFF);
    send_sample(32'h3F80_0000);
    write_scale(32'h0000_0001);
    send_sample(32'h7F7F_FFFF);
    send_sample(32'h4B00_0000);
  endtask

  task automatic test_random_phases();
    logic [31:0] scales[$];
    scales = '{32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h4700_0000, 32'hBF00_0000,
               32'h3A80_0000, 32'h0040_0000};
    for (int p = 0; p < 12; p++) begin
      if (p < scales.size()) write_scale(scales[p]);
      else write_scale({1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)});
      tx_idle_on = (p % 3) != 2;
      rx_idle_on = (p % 4) != 1;
      for (int i = 0; i < 70; i++)
        send_sample(($urandom_range(0, 4) == 0) ? $urandom : near_range_sample());
    end
    write_scale($urandom);
    for (int i = 0; i < 20; i++) send_sample($urandom);
  endtask

  task automatic test_backpressure();
    drain_pipeline();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_sample(near_range_sample());
    drain_pipeline();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    scale_now = SCALE_RESET;
    mismatches = 0;
    cycle_count = 0;
    hold_cycles = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_unity();
    test_special_scales();
    test_backpressure();
    test_random_phases();
    drain_pipeline();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
